[hw/rtl/hgs_pkg.sv]
// Shared types, constants and elaboration-time functions of the gait sequencer.
package hgs_pkg;

   localparam int COS_TABLE_BITS = 10;
   localparam int ANGLE_W        = COS_TABLE_BITS;
   localparam int COS_N          = 1 << COS_TABLE_BITS;
   localparam int COS_Q          = COS_N / 4;
   localparam int QIDX_W         = COS_TABLE_BITS - 1;
   localparam int NUM_W          = 9;
   localparam int DEN_W          = 10;

   localparam int MIN_CYCLE       = 50;
   localparam int LP_STEP_K       = 68361497;   // 20861 * 3277
   localparam int LP_KEEP         = 62259;
   localparam int TRAVEL_LIN_LIM  = 4;
   localparam int TRAVEL_TURN_LIM = 17;
   localparam int REST_LIN_LIM    = 16;
   localparam int REST_YAW_LIM    = 571;
   localparam int HEIGHT_STEP     = 49;
   localparam int LIFT_RESET      = 737;
   localparam int CYCLE_RESET     = 50;

   typedef enum logic [1:0] {
      REG_RIPPLE = 2'd0,
      REG_CYCLE  = 2'd1,
      REG_LIFT   = 2'd2
   } reg_index_type;

   typedef enum logic [3:0] {
      S_IDLE, S_LP_A, S_LP_B, S_LP_C, S_DECIDE, S_DIV_GO, S_DIV_WAIT, S_COS_RD,
      S_COS_WR, S_Z, S_LEG_RD, S_LEG_MUL, S_LEG_WB, S_LEG_OUT, S_END
   } state_type;

   typedef struct packed {
      logic [15:0] yaw;
      logic [13:0] z;
      logic [15:0] y;
      logic [15:0] x;
   } foot_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [ANGLE_W-1:0] quot;
   } div_rsp_type;

   typedef logic [14:0] cos_tab_type [0:COS_Q];
   typedef logic [1:0]  grp6_type [0:5];

   localparam grp6_type TRIPOD_START = '{2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0};
   localparam grp6_type RIPPLE_START = '{2'd1, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1};

   // Q16 product, rounded half away from zero
   function automatic longint mul_round16(longint a, longint b);
      longint p;
      p = a * b;
      if (p >= 0) return (p + 32768) >>> 16;
      return -((-p + 32768) >>> 16);
   endfunction

   function automatic longint quarter_cos(int j);
      longint t;
      longint u;
      longint r;
      t = longint'(j) <<< (18 - COS_TABLE_BITS);
      u = mul_round16(t, t);
      r = 60;
      r = -1367 + mul_round16(r, u);
      r = 16624 + mul_round16(r, u);
      r = -80852 + mul_round16(r, u);
      r = 65536 + mul_round16(r, u);
      if (r < 0) r = 0;
      r = (r + 2) >>> 2;
      if (r > 16384) r = 16384;
      return r;
   endfunction

   function automatic cos_tab_type build_cos_tab();
      cos_tab_type tab;
      for (int j = 0; j <= COS_Q; j++) tab[j] = 15'(quarter_cos(j));
      return tab;
   endfunction

   // product / 4096, rounded half away from zero, saturated to 16 bits
   function automatic logic [15:0] round_sat(logic signed [39:0] p);
      logic signed [40:0] r;
      if (p >= 0) r = (41'(p) + 41'sd2048) >>> 12;
      else        r = -((-41'(p) + 41'sd2048) >>> 12);
      if (r > 41'sd32767)  return 16'h7FFF;
      if (r < -41'sd32768) return 16'h8000;
      return r[15:0];
   endfunction

endpackage

[hw/rtl/hgs_ram.sv]
// Generic single-port-write, registered-read RAM.
module hgs_ram #(
   parameter int WIDTH = 62,
   parameter int DEPTH = 6
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[hw/rtl/hgs_div.sv]
// Radix-2 restoring divider for rounded angle indexes.
module hgs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  hgs_pkg::div_req_type req,
   output hgs_pkg::div_rsp_type rsp
);
   localparam int DVW = hgs_pkg::NUM_W + hgs_pkg::ANGLE_W + 1;
   localparam int CW  = $clog2(DVW + 1);

   logic [DVW-1:0]              dvd_ff;
   logic [hgs_pkg::DEN_W-1:0]   rem_ff;
   logic [CW-1:0]               cnt_ff;
   logic                        done_ff;
   logic [hgs_pkg::DEN_W:0]     trial;
   logic                        fit;

   assign trial = {rem_ff, dvd_ff[DVW-1]};
   assign fit   = trial >= {1'b0, req.den};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            // num * N + den / 2
            dvd_ff <= DVW'({req.num, {hgs_pkg::ANGLE_W{1'b0}}}) + DVW'(req.den[hgs_pkg::DEN_W-1:1]);
            rem_ff <= '0;
            cnt_ff <= CW'(DVW);
         end else if (cnt_ff != '0) begin
            rem_ff <= fit ? hgs_pkg::DEN_W'(trial - {1'b0, req.den})
                          : trial[hgs_pkg::DEN_W-1:0];
            dvd_ff <= {dvd_ff[DVW-2:0], fit};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) done_ff <= 1'b1;
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = dvd_ff[hgs_pkg::ANGLE_W-1:0];
endmodule

[hw/rtl/hexapod_gait_sequencer.sv]
// Top level: hexapod gait sequencer with foot positions held in RAM.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata: cmd_vx, cmd_vy, cmd_wz
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: leg, x, y, z, yaw; tuser, tlast
//  csr     | in  | csr_valid/csr_ready    | csr_index, csr_wdata
//
// A tick filters the command; while the gait runs it then makes four serial angle
// divisions (20 quotient bits, one a cycle) that set the active figure. Each leg steps
// through foot RAM read, multiply, write-back and output; rsp stalls hold the output.
// Reset is synchronous; valid bits make the foot RAM read as zero until written.
// One tick is in flight at a time; req_tready is low until its last leg is taken.
module hexapod_gait_sequencer #(
   parameter int LEG_COUNT = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // cmd_vx[15:0], cmd_vy[31:16], cmd_wz[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // leg_number[2:0], foot_x[18:3], foot_y[34:19],
                                    // foot_z[48:35], foot_yaw[64:49], zero pad
   output logic        rsp_tuser,   // gait_active
   output logic        rsp_tlast,   // last_leg
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata
);
   localparam int LW = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;
   localparam int Q  = hgs_pkg::COS_Q;
   localparam int AW = hgs_pkg::ANGLE_W;
   localparam hgs_pkg::cos_tab_type COS_TAB = hgs_pkg::build_cos_tab();

   hgs_pkg::state_type state_ff, state_in;

   logic               ripple_ff;
   logic [7:0]         cyclen_ff;
   logic [13:0]        lift_ff;
   logic signed [15:0] cmd_ff [3];
   logic signed [23:0] smooth_ff [3];
   logic [7:0]         phase_ff;
   logic               travel_ff, fin_ff, active_ff;
   logic [1:0]         grp_ff [LEG_COUNT];
   logic [LEG_COUNT-1:0] vld_ff, rest_ff;
   logic signed [15:0] cang_ff [4];
   logic [1:0]         k_ff, ax_ff;
   logic [LW-1:0]      leg_ff;
   logic signed [24:0] lpa_ff;
   logic signed [52:0] lpb_ff;
   logic signed [40:0] lpc_ff;
   logic signed [39:0] px_ff, py_ff, pw_ff;
   logic               upd_ff, lift_sel_ff;
   logic [28:0]        zmul_ff;
   logic [14:0]        cosraw_ff;
   logic               cneg_ff;
   hgs_pkg::foot_type  out_ff;

   // combinational
   logic [7:0]         len;
   logic [8:0]         len2;
   logic [9:0]         den_k;
   logic [8:0]         num_k;
   logic [AW-1:0]      idx;
   logic [AW-1:0]      jfull;
   logic               jneg;
   logic signed [63:0] lp_sum, lp_q;
   logic signed [23:0] lp_sat;
   logic               trav_new, fin_new;
   logic [8:0]         settle;
   logic signed [15:0] csel;
   logic               upd_new, lift_new;
   hgs_pkg::foot_type  old_foot, new_foot, ram_rdata;
   logic [13:0]        zval;
   logic               ram_we;
   logic [7:0]         phase_nx;
   hgs_pkg::div_req_type div_req;
   hgs_pkg::div_rsp_type div_rsp;

   assign len  = (cyclen_ff < 8'(hgs_pkg::MIN_CYCLE)) ? 8'(hgs_pkg::MIN_CYCLE) : cyclen_ff;
   assign len2 = {len, 1'b0};

   always_comb begin
      num_k = {1'b0, phase_ff};
      den_k = {1'b0, len2};
      case (k_ff)
         2'd0: num_k = 9'(hgs_pkg::HEIGHT_STEP);
         2'd1: num_k = {1'b0, phase_ff};
         2'd2: den_k = ripple_ff ? {len2, 1'b0} : {1'b0, len2};
         2'd3: begin
            num_k = {1'b0, len} + {1'b0, phase_ff};
            den_k = ripple_ff ? {len2, 1'b0} : {1'b0, len2};
         end
         default: num_k = {1'b0, phase_ff};
      endcase
   end

   assign div_req.start = (state_ff == hgs_pkg::S_DIV_GO);
   assign div_req.num   = num_k;
   assign div_req.den   = den_k;

   hgs_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   // cosine fold into the quarter table
   always_comb begin
      idx = div_rsp.quot + ((k_ff == 2'd0) ? AW'(3 * Q) : '0);
      if (idx <= AW'(Q)) begin
         jfull = idx;                jneg = 1'b0;
      end else if (idx <= AW'(2 * Q)) begin
         jfull = AW'(2 * Q) - idx;   jneg = 1'b1;
      end else if (idx <= AW'(3 * Q)) begin
         jfull = idx - AW'(2 * Q);   jneg = 1'b1;
      end else begin
         jfull = AW'(0) - idx;       jneg = 1'b0;
      end
   end

   // low-pass sum, truncated toward zero, saturated
   always_comb begin
      lp_sum = 64'(lpb_ff) + (64'(lpc_ff) <<< 16);
      if (lp_sum < 0) lp_q = (lp_sum + 64'sh0000_0000_FFFF_FFFF) >>> 32;
      else            lp_q = lp_sum >>> 32;
      if (lp_q > 64'sd8388607)       lp_sat = 24'h7FFFFF;
      else if (lp_q < -64'sd8388608) lp_sat = 24'h800000;
      else                           lp_sat = lp_q[23:0];
   end

   always_comb begin
      trav_new = (smooth_ff[0] > 24'sd4) || (smooth_ff[0] < -24'sd4) ||
                 (smooth_ff[1] > 24'sd4) || (smooth_ff[1] < -24'sd4) ||
                 (smooth_ff[2] > 24'sd17) || (smooth_ff[2] < -24'sd17);
      settle  = len2 - {1'b0, phase_ff};
      fin_new = fin_ff;
      if (!trav_new && (|rest_ff) && ({1'b0, phase_ff} < len2) && (settle > 9'd1))
         fin_new = (settle != 9'd2);
   end

   always_comb begin
      csel     = '0;
      upd_new  = 1'b0;
      lift_new = 1'b0;
      if (active_ff) begin
         case (grp_ff[leg_ff])
            2'd0: if (travel_ff) begin
               csel = cang_ff[1]; upd_new = 1'b1; lift_new = 1'b1;
            end
            2'd1: begin csel = -cang_ff[2]; upd_new = 1'b1; end
            2'd2: begin csel = -cang_ff[3]; upd_new = 1'b1; end
            default: upd_new = 1'b0;
         endcase
      end
   end

   assign old_foot = vld_ff[leg_ff] ? ram_rdata : '0;
   assign zval = (cang_ff[0] <= 16'sd0) ? 14'd0 : 14'((zmul_ff + 29'd8192) >> 14);

   always_comb begin
      new_foot = old_foot;
      if (upd_ff) begin
         new_foot.x   = hgs_pkg::round_sat(px_ff);
         new_foot.y   = hgs_pkg::round_sat(py_ff);
         new_foot.yaw = hgs_pkg::round_sat(pw_ff);
         new_foot.z   = lift_sel_ff ? zval : 14'd0;
      end
   end

   assign ram_we   = (state_ff == hgs_pkg::S_LEG_WB) && upd_ff;
   assign phase_nx = active_ff ? phase_ff + 8'd1 : 8'd0;

   hgs_ram #(.WIDTH($bits(hgs_pkg::foot_type)), .DEPTH(LEG_COUNT)) u_ram (
      .clock(clock), .we(ram_we), .waddr(leg_ff), .wdata(new_foot),
      .raddr(leg_ff), .rdata(ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hgs_pkg::S_IDLE:     if (req_tvalid) state_in = hgs_pkg::S_LP_A;
         hgs_pkg::S_LP_A:     state_in = hgs_pkg::S_LP_B;
         hgs_pkg::S_LP_B:     state_in = hgs_pkg::S_LP_C;
         hgs_pkg::S_LP_C:     state_in = (ax_ff == 2'd2) ? hgs_pkg::S_DECIDE : hgs_pkg::S_LP_A;
         hgs_pkg::S_DECIDE:   state_in = (trav_new || fin_new) ? hgs_pkg::S_DIV_GO
                                                               : hgs_pkg::S_LEG_RD;
         hgs_pkg::S_DIV_GO:   state_in = hgs_pkg::S_DIV_WAIT;
         hgs_pkg::S_DIV_WAIT: if (div_rsp.done) state_in = hgs_pkg::S_COS_RD;
         hgs_pkg::S_COS_RD:   state_in = hgs_pkg::S_COS_WR;
         hgs_pkg::S_COS_WR:   state_in = (k_ff == 2'd3) ? hgs_pkg::S_Z : hgs_pkg::S_DIV_GO;
         hgs_pkg::S_Z:        state_in = hgs_pkg::S_LEG_RD;
         hgs_pkg::S_LEG_RD:   state_in = hgs_pkg::S_LEG_MUL;
         hgs_pkg::S_LEG_MUL:  state_in = hgs_pkg::S_LEG_WB;
         hgs_pkg::S_LEG_WB:   state_in = hgs_pkg::S_LEG_OUT;
         hgs_pkg::S_LEG_OUT:
            if (rsp_tready)
               state_in = (leg_ff == LW'(LEG_COUNT - 1)) ? hgs_pkg::S_END : hgs_pkg::S_LEG_RD;
         hgs_pkg::S_END:      state_in = hgs_pkg::S_IDLE;
         default:             state_in = hgs_pkg::S_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_tready = (state_ff == hgs_pkg::S_IDLE);
      rsp_tvalid = (state_ff == hgs_pkg::S_LEG_OUT);
      csr_ready  = 1'b1;
   end

   assign rsp_tdata = {7'd0, out_ff.yaw, out_ff.z, out_ff.y, out_ff.x, 3'(leg_ff)};
   assign rsp_tuser = active_ff;
   assign rsp_tlast = (leg_ff == LW'(LEG_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= hgs_pkg::S_IDLE;
         ripple_ff <= 1'b0;
         cyclen_ff <= 8'(hgs_pkg::CYCLE_RESET);
         lift_ff   <= 14'(hgs_pkg::LIFT_RESET);
         for (int i = 0; i < 3; i++) smooth_ff[i] <= '0;
         phase_ff  <= '0;
         travel_ff <= 1'b0;
         fin_ff    <= 1'b0;
         active_ff <= 1'b0;
         for (int i = 0; i < LEG_COUNT; i++) grp_ff[i] <= hgs_pkg::TRIPOD_START[i];
         vld_ff    <= '0;
         rest_ff   <= '0;
         k_ff      <= '0;
         ax_ff     <= '0;
         leg_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               hgs_pkg::REG_RIPPLE: begin
                  ripple_ff <= csr_wdata[0];
                  for (int i = 0; i < LEG_COUNT; i++)
                     grp_ff[i] <= csr_wdata[0] ? hgs_pkg::RIPPLE_START[i]
                                               : hgs_pkg::TRIPOD_START[i];
               end
               hgs_pkg::REG_CYCLE: cyclen_ff <= csr_wdata[7:0];
               hgs_pkg::REG_LIFT:  lift_ff   <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            hgs_pkg::S_IDLE: if (req_tvalid) begin
               cmd_ff[0] <= req_tdata[15:0];
               cmd_ff[1] <= req_tdata[31:16];
               cmd_ff[2] <= req_tdata[47:32];
               ax_ff     <= '0;
            end
            hgs_pkg::S_LP_A: lpa_ff <= cmd_ff[ax_ff] * $signed({1'b0, len});
            hgs_pkg::S_LP_B: begin
               lpb_ff <= lpa_ff * $signed({1'b0, 27'(hgs_pkg::LP_STEP_K)});
               lpc_ff <= smooth_ff[ax_ff] * $signed({1'b0, 16'(hgs_pkg::LP_KEEP)});
            end
            hgs_pkg::S_LP_C: begin
               smooth_ff[ax_ff] <= lp_sat;
               ax_ff <= ax_ff + 2'd1;
            end
            hgs_pkg::S_DECIDE: begin
               travel_ff <= trav_new;
               fin_ff    <= fin_new;
               active_ff <= trav_new || fin_new;
               k_ff      <= '0;
               leg_ff    <= '0;
            end
            hgs_pkg::S_COS_RD: begin
               cosraw_ff <= COS_TAB[jfull[hgs_pkg::QIDX_W-1:0]];
               cneg_ff   <= jneg;
            end
            hgs_pkg::S_COS_WR: begin
               cang_ff[k_ff] <= cneg_ff ? -$signed({1'b0, cosraw_ff}) : $signed({1'b0, cosraw_ff});
               k_ff <= k_ff + 2'd1;
            end
            hgs_pkg::S_Z: zmul_ff <= lift_ff * cang_ff[0][14:0];
            hgs_pkg::S_LEG_MUL: begin
               px_ff       <= smooth_ff[0] * csel;
               py_ff       <= smooth_ff[1] * csel;
               pw_ff       <= smooth_ff[2] * csel;
               upd_ff      <= upd_new;
               lift_sel_ff <= lift_new;
            end
            hgs_pkg::S_LEG_WB: begin
               out_ff <= new_foot;
               if (upd_ff) begin
                  vld_ff[leg_ff]  <= 1'b1;
                  rest_ff[leg_ff] <=
                     ($signed(new_foot.x) > 16'sd16) || ($signed(new_foot.x) < -16'sd16) ||
                     ($signed(new_foot.y) > 16'sd16) || ($signed(new_foot.y) < -16'sd16) ||
                     ($signed(new_foot.yaw) > 16'sd571) ||
                     ($signed(new_foot.yaw) < -16'sd571) || (new_foot.z > 14'd16);
               end
            end
            hgs_pkg::S_LEG_OUT:
               if (rsp_tready && leg_ff != LW'(LEG_COUNT - 1)) leg_ff <= leg_ff + 1'b1;
            hgs_pkg::S_END: begin
               if (phase_nx >= len) begin
                  phase_ff <= '0;
                  for (int i = 0; i < LEG_COUNT; i++) begin
                     if (grp_ff[i] == 2'd0)                 grp_ff[i] <= 2'd1;
                     else if (grp_ff[i] == 2'd1 && ripple_ff) grp_ff[i] <= 2'd2;
                     else                                   grp_ff[i] <= 2'd0;
                  end
               end else begin
                  phase_ff <= phase_nx;
               end
            end
            default: ;
         endcase
      end
   end

   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken while a leg result is pending");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == hgs_pkg::S_DIV_WAIT))
      else $error("divider finished outside its wait state");

   a_write_needs_active: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> active_ff) else $error("foot RAM written on an idle tick");

   a_last_leg_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (state_ff == hgs_pkg::S_END))
      else $error("tick did not close after its last leg");
endmodule
